/* rtl/core/geq_pkg.sv */
`default_nettype none
package geq_pkg;

  localparam int CHANNELS = 2;
  localparam int BANDS    = 10;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BAND_W  = (BANDS > 1) ? $clog2(BANDS) : 1;
  localparam int COEF_AW = BAND_W + 2;
  localparam int HIST_AW = 1 + CH_W + BAND_W;

  localparam logic [1:0] FN_SAMPLE = 2'd0;
  localparam logic [1:0] FN_COEF   = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [1:0] KIND_ALPHA = 2'd0;
  localparam logic [1:0] KIND_BETA  = 2'd1;
  localparam logic [1:0] KIND_GAMMA = 2'd2;
  localparam logic [1:0] KIND_AMP   = 2'd3;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_TWO    = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;
  localparam logic [1:0] REG_IFAC   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_ALPHA, ST_GAMMA, ST_BETA, ST_SUM3, ST_YOUT,
    ST_AMP, ST_ACC, ST_DRY, ST_DRYACC, ST_SAT, ST_GAIN, ST_GRND
  } state_t;

  typedef struct packed {
    logic        enable;
    logic        two_pass;
    logic [25:0] gain;
    logic [20:0] ifac;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [COEF_AW-1:0] addr;
    logic signed [23:0] wdata;
  } coef_req_t;

  typedef struct packed {
    logic               we;
    logic               clr;
    logic [HIST_AW-1:0] waddr;
    logic [HIST_AW-1:0] raddr;
    logic [63:0]        wdata;
  } hist_req_t;

  function automatic logic signed [63:0] rescale(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd524288;
    return t >>> 20;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    else if (v < -64'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/geq_if.sv */
`default_nettype none
interface geq_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               channel;
  logic signed [23:0] sample_in;
  logic [3:0]         coef_band;
  logic [1:0]         coef_kind;
  logic signed [23:0] coef_value;
  modport source(output valid, func, channel, sample_in, coef_band, coef_kind, coef_value,
                 input ready);
  modport sink(input valid, func, channel, sample_in, coef_band, coef_kind, coef_value,
               output ready);
endinterface

interface geq_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_out;
  logic               channel_out;
  modport source(output valid, sample_out, channel_out, input ready);
  modport sink(input valid, sample_out, channel_out, output ready);
endinterface
`default_nettype wire

/* rtl/core/geq_coef_mem.sv */
`default_nettype none
module geq_coef_mem (
  input  wire                 clk,
  input  wire                 rst_n,
  input  geq_pkg::coef_req_t  req,
  output logic signed [23:0]  rdata
);
  import geq_pkg::*;

  logic signed [23:0] mem [2**COEF_AW];
  logic [2**COEF_AW-1:0] valid_r;
  logic signed [23:0] q_r;
  logic v_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    q_r <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      v_r     <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.addr] <= 1'b1;
      end
      v_r <= valid_r[req.addr];
    end
  end

  assign rdata = v_r ? q_r : 24'sd0;
endmodule
`default_nettype wire

/* rtl/core/geq_hist_mem.sv */
`default_nettype none
module geq_hist_mem (
  input  wire                 clk,
  input  wire                 rst_n,
  input  geq_pkg::hist_req_t  req,
  output logic [63:0]         rdata
);
  import geq_pkg::*;

  logic [63:0] mem [2**HIST_AW];
  logic [2**HIST_AW-1:0] valid_r;
  logic [63:0] q_r;
  logic v_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    q_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      valid_r <= '0;
      v_r     <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      v_r <= valid_r[req.raddr];
    end
  end

  assign rdata = v_r ? q_r : 64'd0;
endmodule
`default_nettype wire

/* rtl/core/geq_seq.sv */
`default_nettype none
module geq_seq (
  input  wire                 clk,
  input  wire                 rst_n,
  geq_in_if.sink              in_ch,
  geq_out_if.source           out_ch,
  input  geq_pkg::cfg_t       cfg,
  output geq_pkg::coef_req_t  coef_req,
  input  wire signed [23:0]   coef_rdata,
  output geq_pkg::hist_req_t  hist_req,
  input  wire [63:0]          hist_rdata
);
  import geq_pkg::*;

  state_t state_r, state_nxt;
  logic [BAND_W-1:0] band_r;
  logic pass_r, gcnt_r;
  logic [CH_W-1:0] ch_r;
  logic signed [23:0] x_r;
  logic signed [31:0] xin_r, y1_r, y2_r, y_r, s_r;
  logic signed [32:0] diff_r;
  logic signed [23:0] amp_r;
  logic signed [60:0] prod_r;
  logic signed [63:0] acc_r, sum_r;
  logic signed [31:0] ih0_r [2][CHANNELS];
  logic signed [31:0] ih1_r [2][CHANNELS];
  logic out_valid_r;
  logic signed [23:0] out_data_r;
  logic out_ch_r;

  logic signed [33:0] mul_a;
  logic signed [26:0] mul_b;
  logic accept, is_sample, last_band, out_free;
  logic signed [31:0] y_new, s_new;
  logic signed [63:0] r_new;
  logic [HIST_AW-1:0] hist_addr;

  assign accept    = in_ch.valid && in_ch.ready;
  assign is_sample = (in_ch.func == FN_SAMPLE) && (int'(in_ch.channel) < CHANNELS);
  assign last_band = (band_r == BAND_W'(BANDS - 1));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign y_new     = sat32(rescale(acc_r));
  assign s_new     = sat32(rescale(sum_r));
  assign r_new     = rescale(64'(prod_r));
  assign hist_addr = {pass_r, ch_r, band_r};

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.sample_out  = out_data_r;
  assign out_ch.channel_out = out_ch_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept && is_sample) state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_ALPHA;
      ST_ALPHA:  state_nxt = ST_GAMMA;
      ST_GAMMA:  state_nxt = ST_BETA;
      ST_BETA:   state_nxt = ST_SUM3;
      ST_SUM3:   state_nxt = ST_YOUT;
      ST_YOUT:   state_nxt = ST_AMP;
      ST_AMP:    state_nxt = ST_ACC;
      ST_ACC:    state_nxt = last_band ? ST_DRY : ST_RD;
      ST_DRY:    state_nxt = ST_DRYACC;
      ST_DRYACC: state_nxt = ST_SAT;
      ST_SAT:    state_nxt = (cfg.two_pass && !pass_r) ? ST_RD : ST_GAIN;
      ST_GAIN:   state_nxt = ST_GRND;
      ST_GRND: begin
        if (cfg.two_pass && !gcnt_r) state_nxt = ST_GAIN;
        else if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory requests and multiplier operands
  always_comb begin
    coef_req.we    = 1'b0;
    coef_req.addr  = {band_r, KIND_ALPHA};
    coef_req.wdata = in_ch.coef_value;
    hist_req.we    = 1'b0;
    hist_req.clr   = 1'b0;
    hist_req.waddr = hist_addr;
    hist_req.raddr = hist_addr;
    hist_req.wdata = {y_new, y1_r};
    mul_a = 34'(diff_r);
    mul_b = 27'(coef_rdata);
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_ch.func == FN_COEF && int'(in_ch.coef_band) < BANDS) begin
          coef_req.we   = 1'b1;
          coef_req.addr = {BAND_W'(in_ch.coef_band), in_ch.coef_kind};
        end
        hist_req.clr = accept && (in_ch.func == FN_CLEAR);
      end
      ST_ALPHA: coef_req.addr = {band_r, KIND_GAMMA};
      ST_GAMMA: begin
        coef_req.addr = {band_r, KIND_BETA};
        mul_a = 34'(y1_r);
      end
      ST_BETA: begin
        coef_req.addr = {band_r, KIND_AMP};
        mul_a = 34'(y2_r);
      end
      ST_YOUT: hist_req.we = 1'b1;
      ST_AMP: begin
        mul_a = 34'(y_r);
        mul_b = 27'(amp_r);
      end
      ST_DRY: begin
        mul_a = 34'(xin_r);
        mul_b = $signed({6'd0, cfg.ifac});
      end
      ST_GAIN, ST_GRND: begin
        mul_a = 34'(s_r);
        mul_b = $signed({1'b0, cfg.gain});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int p = 0; p < 2; p++) begin
        for (int c = 0; c < CHANNELS; c++) begin
          ih0_r[p][c] <= '0;
          ih1_r[p][c] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_GRND && !(cfg.two_pass && !gcnt_r) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_IDLE && accept && in_ch.func == FN_CLEAR) begin
        for (int p = 0; p < 2; p++) begin
          for (int c = 0; c < CHANNELS; c++) begin
            ih0_r[p][c] <= '0;
            ih1_r[p][c] <= '0;
          end
        end
      end
      if (state_r == ST_SAT) begin
        ih1_r[pass_r][ch_r] <= ih0_r[pass_r][ch_r];
        ih0_r[pass_r][ch_r] <= xin_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        x_r    <= in_ch.sample_in;
        xin_r  <= 32'(in_ch.sample_in);
        ch_r   <= CH_W'(in_ch.channel);
        pass_r <= 1'b0;
        gcnt_r <= 1'b0;
        band_r <= '0;
        sum_r  <= '0;
      end
      ST_RD:    diff_r <= 33'(xin_r) - 33'(ih1_r[pass_r][ch_r]);
      ST_ALPHA: begin
        y1_r <= hist_rdata[63:32];
        y2_r <= hist_rdata[31:0];
      end
      ST_GAMMA: acc_r <= 64'(prod_r);
      ST_BETA:  acc_r <= acc_r + 64'(prod_r);
      ST_SUM3: begin
        acc_r <= acc_r - 64'(prod_r);
        amp_r <= coef_rdata;
      end
      ST_YOUT:  y_r <= y_new;
      ST_ACC: begin
        sum_r <= sum_r + 64'(prod_r);
        if (!last_band) band_r <= band_r + 1'b1;
      end
      ST_DRYACC: sum_r <= sum_r + 64'(prod_r);
      ST_SAT: begin
        s_r <= s_new;
        if (cfg.two_pass && !pass_r) begin
          pass_r <= 1'b1;
          xin_r  <= s_new;
          band_r <= '0;
          sum_r  <= '0;
        end
      end
      ST_GRND: begin
        if (cfg.two_pass && !gcnt_r) begin
          s_r    <= sat32(r_new);
          gcnt_r <= 1'b1;
        end else if (out_free) begin
          out_data_r <= cfg.enable ? sat24(r_new) : x_r;
          out_ch_r   <= ch_r[0];
        end
      end
      default: ;
    endcase
  end

  a_hist_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !hist_req.we)
    else $error("history write while idle");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_sample) |=> (state_r == ST_RD))
    else $error("sample accepted without starting the bank");

  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (int'(band_r) < BANDS))
    else $error("band index out of range");
endmodule
`default_nettype wire

/* rtl/core/graphic_equalizer_bandpass_bank.sv */
// channel   dir  protocol         word
// in_ch     in   valid/ready      func, channel, sample_in, coef_band, coef_kind, coef_value
// out_ch    out  valid/ready      sample_out, channel_out
// cfg (apb) in   psel/penable     enable_filter, two_pass, global_gain, input_factor
//
// sample: every product, in one pass or two, comes from the single shared
//   multiplier, which takes four products per band
// coefficient write and history clear are done while idle, other words are dropped
// history and coefficient memories read as zero after reset through valid bits
// a finished word waits in the output register; the next word is taken meanwhile
`default_nettype none
module graphic_equalizer_bandpass_bank (
  input  wire         clk,
  input  wire         rst_n,
  geq_in_if.sink      in_ch,
  geq_out_if.source   out_ch,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire [3:0]   paddr,
  input  wire [31:0]  pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import geq_pkg::*;

  cfg_t cfg_r;
  coef_req_t coef_req;
  hist_req_t hist_req;
  logic signed [23:0] coef_rdata;
  logic [63:0] hist_rdata;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable   <= 1'b1;
      cfg_r.two_pass <= 1'b0;
      cfg_r.gain     <= 26'd1048576;
      cfg_r.ifac     <= 21'd262144;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_ENABLE: cfg_r.enable   <= pwdata[0];
        REG_TWO:    cfg_r.two_pass <= pwdata[0];
        REG_GAIN:   cfg_r.gain     <= pwdata[25:0];
        REG_IFAC:   cfg_r.ifac     <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, cfg_r.enable};
      REG_TWO:    prdata = {31'd0, cfg_r.two_pass};
      REG_GAIN:   prdata = {6'd0, cfg_r.gain};
      REG_IFAC:   prdata = {11'd0, cfg_r.ifac};
      default:    prdata = '0;
    endcase
  end

  geq_coef_mem u_coef (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (coef_req),
    .rdata (coef_rdata)
  );

  geq_hist_mem u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rdata (hist_rdata)
  );

  geq_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg        (cfg_r),
    .coef_req   (coef_req),
    .coef_rdata (coef_rdata),
    .hist_req   (hist_req),
    .hist_rdata (hist_rdata)
  );
endmodule
`default_nettype wire
